FILE: rtl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; every other file in rtl/ uses this package.
`timescale 1ns / 1ps

package uer_pkg;

    // Width of each result field and of the config port
    localparam int DIST_W     = 19;
    localparam int TICK_W     = 16;
    localparam int SCALE_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Tick count per centimeter of round trip (distance = count * scale / 58)
    localparam int DIVISOR = 58;
    localparam int REM_W   = 6;

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_TMO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 3'd4;

    // Measurement phases
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LOW   = 3'd1,
        PH_HIGH  = 3'd2,
        PH_WAIT  = 3'd3,
        PH_COUNT = 3'd4
    } phase_t;

    // One input word per tick
    typedef struct packed {
        logic start_req;
        logic echo_level;
    } in_word_t;

    // One result word per tick
    typedef struct packed {
        logic              trigger_level;
        logic              busy_res;
        logic              done_res;
        logic              timed_out;
        logic              distance_valid;
        logic [DIST_W-1:0] distance_tenths;
    } out_word_t;

endpackage

FILE: rtl/uer_div58_step.sv
// One step of the running quotient/remainder of count * scale / 58.
// Adds scale to the remainder and carries whole multiples of 58 into the quotient.
// Depends on uer_pkg.
`timescale 1ns / 1ps

module uer_div58_step (
    input  logic [uer_pkg::DIST_W-1:0]  q_in,
    input  logic [uer_pkg::REM_W-1:0]   r_in,
    input  logic [uer_pkg::SCALE_W-1:0] scale,
    output logic [uer_pkg::DIST_W-1:0]  q_out,
    output logic [uer_pkg::REM_W-1:0]   r_out
);

    // r_in < 58 and scale < 256, so the sum stays below 6 * 58
    localparam int SUM_W = uer_pkg::SCALE_W + 1;
    localparam int NCMP  = 5;

    logic [SUM_W-1:0] sum;
    logic [2:0]       carry;
    logic [SUM_W-1:0] sub;

    assign sum = SUM_W'(r_in) + SUM_W'(scale);

    // Count how many multiples of 58 fit in the sum
    always_comb begin
        carry = 3'd0;
        for (int j = 1; j <= NCMP; j++) begin
            if (sum >= SUM_W'(j * uer_pkg::DIVISOR)) begin
                carry = carry + 3'd1;
            end
        end
    end

    assign sub   = SUM_W'(carry) * SUM_W'(uer_pkg::DIVISOR);
    assign r_out = uer_pkg::REM_W'(sum - sub);
    assign q_out = q_in + uer_pkg::DIST_W'(carry);

endmodule

FILE: rtl/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger: top level with trigger/echo sequencer and result register.
// Depends on uer_pkg and uer_div58_step.
`timescale 1ns / 1ps

// Each input word is one timebase tick carrying a start request and the sampled
// echo level; each accepted word yields exactly one registered result word,
// and a new word is accepted every cycle (the result register is refilled as it
// drains, so throughput is one word per clock while m_ready stays high). A start
// in idle drives the trigger low for max(trigger_low_ticks,1) ticks, high for
// max(trigger_high_ticks,1) ticks, then waits up to rise_timeout_ticks for the
// echo and counts its high ticks up to echo_limit_ticks. The distance
// floor(count * scale_tenths / 58) is kept as a running quotient and remainder
// updated once per echo tick, so no divider sits in the path. Config writes are
// always accepted and must only be made while the block is idle.
module ultrasonic_echo_ranger (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data,
    // tick input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  uer_pkg::in_word_t             s_data,
    // result output
    output logic                          m_valid,
    input  logic                          m_ready,
    output uer_pkg::out_word_t            m_data
);

    localparam int TW = uer_pkg::TICK_W;
    localparam int DW = uer_pkg::DIST_W;
    localparam int RW = uer_pkg::REM_W;

    // Config registers
    logic [7:0]                  trig_low_reg;
    logic [7:0]                  trig_high_reg;
    logic [TW-1:0]               rise_tmo_reg;
    logic [TW-1:0]               echo_limit_reg;
    logic [uer_pkg::SCALE_W-1:0] scale_reg;

    // Measurement state
    uer_pkg::phase_t phase_reg, phase_next;
    logic [TW-1:0]   ticks_reg, ticks_next;
    logic [TW-1:0]   count_reg, count_next;
    logic [DW-1:0]   q_reg, q_next;
    logic [RW-1:0]   r_reg, r_next;

    // Result register
    logic               m_valid_reg;
    uer_pkg::out_word_t m_data_reg;
    uer_pkg::out_word_t out_word;

    logic s_accept;
    logic echo;
    logic start;

    logic [TW-1:0] ticks_plus;
    logic [TW:0]   count_plus;
    logic          count_over;
    logic          done;
    logic          tmo;

    logic [DW-1:0] step_q_in, step_q_out;
    logic [RW-1:0] step_r_in, step_r_out;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign echo  = s_data.echo_level;
    assign start = s_data.start_req;

    // Config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_low_reg   <= 8'd2;
            trig_high_reg  <= 8'd10;
            rise_tmo_reg   <= 16'd30000;
            echo_limit_reg <= 16'd30000;
            scale_reg      <= 8'd40;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                uer_pkg::CFG_TRIG_LOW:   trig_low_reg   <= cfg_data[7:0];
                uer_pkg::CFG_TRIG_HIGH:  trig_high_reg  <= cfg_data[7:0];
                uer_pkg::CFG_RISE_TMO:   rise_tmo_reg   <= cfg_data;
                uer_pkg::CFG_ECHO_LIMIT: echo_limit_reg <= cfg_data;
                uer_pkg::CFG_SCALE:      scale_reg      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Running distance: a rising echo starts from zero
    assign step_q_in = (phase_reg == uer_pkg::PH_WAIT) ? '0 : q_reg;
    assign step_r_in = (phase_reg == uer_pkg::PH_WAIT) ? '0 : r_reg;

    uer_div58_step u_step (
        .q_in  (step_q_in),
        .r_in  (step_r_in),
        .scale (scale_reg),
        .q_out (step_q_out),
        .r_out (step_r_out)
    );

    // End-of-measurement events
    assign ticks_plus = ticks_reg + 16'd1;
    assign count_plus = {1'b0, count_reg} + 17'd1;
    assign count_over = count_plus > {1'b0, echo_limit_reg};

    always_comb begin
        done = 1'b0;
        tmo  = 1'b0;
        case (phase_reg)
            uer_pkg::PH_WAIT: begin
                if (echo) begin
                    done = (echo_limit_reg == '0);
                end else begin
                    done = (ticks_plus >= rise_tmo_reg);
                end
                tmo = done;
            end
            uer_pkg::PH_COUNT: begin
                done = !echo || count_over;
                tmo  = echo && count_over;
            end
            default: ;
        endcase
    end

    // Next state
    always_comb begin
        phase_next = phase_reg;
        ticks_next = ticks_reg;
        count_next = count_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        case (phase_reg)
            uer_pkg::PH_LOW: begin
                if (ticks_plus >= {8'd0, trig_low_reg}) begin
                    phase_next = uer_pkg::PH_HIGH;
                    ticks_next = '0;
                end else begin
                    ticks_next = ticks_plus;
                end
            end
            uer_pkg::PH_HIGH: begin
                if (ticks_plus >= {8'd0, trig_high_reg}) begin
                    phase_next = uer_pkg::PH_WAIT;
                    ticks_next = '0;
                end else begin
                    ticks_next = ticks_plus;
                end
            end
            uer_pkg::PH_WAIT: begin
                if (echo) begin
                    phase_next = uer_pkg::PH_COUNT;
                    ticks_next = '0;
                    count_next = 16'd1;
                    q_next     = step_q_out;
                    r_next     = step_r_out;
                end else begin
                    ticks_next = ticks_plus;
                end
            end
            uer_pkg::PH_COUNT: begin
                if (echo) begin
                    count_next = count_plus[TW-1:0];
                    q_next     = step_q_out;
                    r_next     = step_r_out;
                end
            end
            default: begin
                // idle, and any unused code
                phase_next = uer_pkg::PH_IDLE;
                if (start) begin
                    count_next = '0;
                    q_next     = '0;
                    r_next     = '0;
                    if (trig_low_reg <= 8'd1) begin
                        phase_next = uer_pkg::PH_HIGH;
                        ticks_next = '0;
                    end else begin
                        phase_next = uer_pkg::PH_LOW;
                        ticks_next = 16'd1;
                    end
                end
            end
        endcase
        if (done) begin
            phase_next = uer_pkg::PH_IDLE;
            ticks_next = '0;
            count_next = '0;
            q_next     = '0;
            r_next     = '0;
        end
    end

    // Result word for this tick
    always_comb begin
        out_word                 = '0;
        out_word.trigger_level   = (phase_reg == uer_pkg::PH_HIGH);
        out_word.done_res        = done;
        out_word.timed_out       = tmo;
        case (phase_reg)
            uer_pkg::PH_LOW, uer_pkg::PH_HIGH: out_word.busy_res = 1'b1;
            uer_pkg::PH_WAIT, uer_pkg::PH_COUNT: out_word.busy_res = !done;
            default: out_word.busy_res = start;
        endcase
        if (done && !tmo) begin
            out_word.distance_tenths = q_reg;
            out_word.distance_valid  = (q_reg != '0);
        end
    end

    // State registers advance once per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= uer_pkg::PH_IDLE;
            ticks_reg <= '0;
            count_reg <= '0;
            q_reg     <= '0;
            r_reg     <= '0;
        end else if (s_accept) begin
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
            count_reg <= count_next;
            q_reg     <= q_next;
            r_reg     <= r_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= out_word;
        end
    end

endmodule

FILE: dv/ultrasonic_echo_ranger_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ultrasonic_echo_ranger: a per-tick ranging predictor checks each
// result word field by field. Depends on uer_pkg and the ultrasonic_echo_ranger RTL.

module ultrasonic_echo_ranger_tb;

    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    localparam int unsigned CM_DIVISOR      = 58;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned MAX_PRINTS      = 40;
    localparam int unsigned RANDOM_PHASES   = 5;
    localparam int unsigned WORDS_PER_PHASE = 60;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [uer_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    uer_pkg::in_word_t              s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    uer_pkg::out_word_t             m_data;

    ultrasonic_echo_ranger dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Predicted ranger state and register copy
    uer_pkg::phase_t            rng_phase;
    logic [uer_pkg::TICK_W-1:0] rng_ticks;
    logic [uer_pkg::TICK_W-1:0] rng_count;
    logic [7:0]                 trig_low_q;
    logic [7:0]                 trig_high_q;
    logic [uer_pkg::TICK_W-1:0] rise_tmo_q;
    logic [uer_pkg::TICK_W-1:0] echo_limit_q;
    logic [7:0]                 scale_q;

    uer_pkg::in_word_t  pending_ticks[$];
    uer_pkg::out_word_t predicted_words[$];

    int unsigned words_queued = 0;
    int unsigned words_taken  = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;
    int unsigned meas_done    = 0;
    int unsigned tmo_seen     = 0;
    int unsigned valid_seen   = 0;
    int unsigned max_dist     = 0;
    int unsigned settings     = 0;

    // Handshake bookkeeping for the pacing processes
    logic        in_taken  = 1'b0;
    logic        out_taken = 1'b0;
    bit          no_idle   = 1'b0;
    bit          want_hold = 1'b0;
    bit          hold_used = 1'b0;
    logic        rx_hold   = 1'b0;
    int unsigned hold_left = 0;
    int unsigned tx_gap    = 0;
    int unsigned rx_gap    = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // One tick of the ranger: advances the predicted state, returns the result word
    function automatic uer_pkg::out_word_t advance_ranger(input uer_pkg::in_word_t w);
        uer_pkg::out_word_t r;
        logic               finish;
        int unsigned        prod;
        r          = '0;
        r.busy_res = 1'b1;
        finish     = 1'b0;
        case (rng_phase)
            uer_pkg::PH_LOW: begin
                rng_ticks = rng_ticks + 1'b1;
                if (rng_ticks >= {8'd0, trig_low_q}) begin
                    rng_phase = uer_pkg::PH_HIGH;
                    rng_ticks = '0;
                end
            end
            uer_pkg::PH_HIGH: begin
                r.trigger_level = 1'b1;
                rng_ticks = rng_ticks + 1'b1;
                if (rng_ticks >= {8'd0, trig_high_q}) begin
                    rng_phase = uer_pkg::PH_WAIT;
                    rng_ticks = '0;
                end
            end
            uer_pkg::PH_WAIT: begin
                if (w.echo_level) begin
                    rng_ticks = '0;
                    if (echo_limit_q == '0) begin
                        finish      = 1'b1;
                        r.timed_out = 1'b1;
                    end else begin
                        rng_count = 16'd1;
                        rng_phase = uer_pkg::PH_COUNT;
                    end
                end else begin
                    rng_ticks = rng_ticks + 1'b1;
                    if (rng_ticks >= rise_tmo_q) begin
                        finish      = 1'b1;
                        r.timed_out = 1'b1;
                    end
                end
            end
            uer_pkg::PH_COUNT: begin
                if (w.echo_level) begin
                    if (({1'b0, rng_count} + 17'd1) > {1'b0, echo_limit_q}) begin
                        finish      = 1'b1;
                        r.timed_out = 1'b1;
                    end else begin
                        rng_count = rng_count + 1'b1;
                    end
                end else begin
                    finish            = 1'b1;
                    prod              = 32'(rng_count) * 32'(scale_q);
                    r.distance_tenths = uer_pkg::DIST_W'(prod / CM_DIVISOR);
                    r.distance_valid  = (prod / CM_DIVISOR) != 0;
                end
            end
            default: begin
                if (w.start_req) begin
                    rng_ticks = 16'd1;
                    rng_count = '0;
                    if (rng_ticks >= {8'd0, trig_low_q}) begin
                        rng_phase = uer_pkg::PH_HIGH;
                        rng_ticks = '0;
                    end else begin
                        rng_phase = uer_pkg::PH_LOW;
                    end
                end else begin
                    r.busy_res = 1'b0;
                    rng_phase  = uer_pkg::PH_IDLE;
                end
            end
        endcase
        if (finish) begin
            r.busy_res = 1'b0;
            r.done_res = 1'b1;
            rng_phase  = uer_pkg::PH_IDLE;
            rng_ticks  = '0;
            rng_count  = '0;
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] result word %0d %s: got %0d, want %0d",
                     $time, results_seen, field, got, want);
    endtask

    task automatic check_word(input uer_pkg::out_word_t got);
        uer_pkg::out_word_t want;
        if (predicted_words.size() == 0) begin
            flag_mismatch("arrived with nothing expected", 1, 0);
        end else begin
            want = predicted_words.pop_front();
            if (got.trigger_level !== want.trigger_level)
                flag_mismatch("trigger_level", 32'(got.trigger_level),
                              32'(want.trigger_level));
            if (got.busy_res !== want.busy_res)
                flag_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
            if (got.done_res !== want.done_res)
                flag_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
            if (got.timed_out !== want.timed_out)
                flag_mismatch("timed_out", 32'(got.timed_out), 32'(want.timed_out));
            if (got.distance_valid !== want.distance_valid)
                flag_mismatch("distance_valid", 32'(got.distance_valid),
                              32'(want.distance_valid));
            if (got.distance_tenths !== want.distance_tenths)
                flag_mismatch("distance_tenths", 32'(got.distance_tenths),
                              32'(want.distance_tenths));
            if (want.done_res) meas_done++;
            if (want.timed_out) tmo_seen++;
            if (want.distance_valid) valid_seen++;
            if (32'(want.distance_tenths) > max_dist) max_dist = 32'(want.distance_tenths);
            results_seen++;
        end
    endtask

    // Rising edge: predict accepted words, check returned words, watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            rng_phase    = uer_pkg::PH_IDLE;
            rng_ticks    = '0;
            rng_count    = '0;
            trig_low_q   = 8'd2;
            trig_high_q  = 8'd10;
            rise_tmo_q   = 16'd30000;
            echo_limit_q = 16'd30000;
            scale_q      = 8'd40;
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end else if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            cycle_count++;
            in_taken  <= s_valid && s_ready;
            out_taken <= m_valid && m_ready;
            if (s_valid && s_ready) begin
                predicted_words.push_back(advance_ranger(s_data));
                words_taken++;
            end
            if (m_valid && m_ready) check_word(m_data);
        end
    end

    // Tick word driver, fed from pending_ticks
    always @(negedge aclk) begin : drive_ticks
        logic offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            offer = s_valid;
            if (s_valid && in_taken) begin
                offer = 1'b0;
                if ($urandom_range(0, 31) == 0) tx_steady = !tx_steady;
                tx_gap = (tx_steady || no_idle) ? 0 : $urandom_range(0, 9);
            end
            if (!offer) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                end else if (pending_ticks.size() != 0) begin
                    s_data <= pending_ticks.pop_front();
                    offer = 1'b1;
                end
            end
            s_valid <= offer;
        end
    end

    // Result receiver pacing
    always @(negedge aclk) begin : pace_results
        logic take;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (out_taken) begin
                if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
                rx_gap = (rx_steady || no_idle) ? 0 : $urandom_range(0, 9);
            end
            if (rx_hold) begin
                take = 1'b0;
            end else if (rx_gap != 0) begin
                take = 1'b0;
                rx_gap--;
            end else begin
                take = 1'b1;
            end
            m_ready <= take;
        end
    end

    // Long receiver stall, once, so the block backs up and stalls its input
    always @(negedge aclk) begin
        if (!aresetn) begin
            rx_hold <= 1'b0;
        end else if (want_hold && !hold_used) begin
            rx_hold  <= 1'b1;
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left--;
            if (hold_left == 0) rx_hold <= 1'b0;
        end
    end

    task automatic push_word(input bit start, input bit echo);
        uer_pkg::in_word_t w;
        w.start_req  = start;
        w.echo_level = echo;
        pending_ticks.push_back(w);
        words_queued++;
    endtask

    // Wait until every queued word is accepted and its result checked
    task automatic wait_drained();
        while (words_taken != words_queued || results_seen != words_taken) begin
            @(posedge aclk);
            #1;
        end
    endtask

    // Drain, then walk any running measurement back to idle
    task automatic settle();
        wait_drained();
        while (rng_phase != uer_pkg::PH_IDLE) begin
            push_word(1'b0, rng_phase == uer_pkg::PH_WAIT);
            wait_drained();
        end
    endtask

    task automatic write_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                             input logic [uer_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            uer_pkg::CFG_TRIG_LOW:   trig_low_q   = val[7:0];
            uer_pkg::CFG_TRIG_HIGH:  trig_high_q  = val[7:0];
            uer_pkg::CFG_RISE_TMO:   rise_tmo_q   = val;
            uer_pkg::CFG_ECHO_LIMIT: echo_limit_q = val;
            uer_pkg::CFG_SCALE:      scale_q      = val[7:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_ranger(input int unsigned tl, input int unsigned th,
                                  input int unsigned rise, input int unsigned lim,
                                  input int unsigned scl);
        write_reg(uer_pkg::CFG_TRIG_LOW, 16'(tl));
        write_reg(uer_pkg::CFG_TRIG_HIGH, 16'(th));
        write_reg(uer_pkg::CFG_RISE_TMO, 16'(rise));
        write_reg(uer_pkg::CFG_ECHO_LIMIT, 16'(lim));
        write_reg(uer_pkg::CFG_SCALE, 16'(scl));
        settings++;
        @(posedge aclk);
        #1;
    endtask

    // One well-formed measurement: start, trigger ticks, low echo, high echo, fall.
    // Stops early where a rise or echo timeout ends it. Starts while busy are random.
    task automatic add_measurement(input int unsigned rise_wait, input int unsigned echo_len,
                                   input bit fall_start);
        int unsigned trig_words;
        int unsigned eff_rise;
        int unsigned high_words;
        trig_words = ((trig_low_q == '0) ? 1 : 32'(trig_low_q))
                   + ((trig_high_q == '0) ? 1 : 32'(trig_high_q)) - 1;
        eff_rise   = (rise_tmo_q == '0) ? 1 : 32'(rise_tmo_q);
        push_word(1'b1, 1'($urandom));
        repeat (trig_words) push_word(1'($urandom), 1'($urandom));
        repeat (rise_wait < eff_rise ? rise_wait : eff_rise) push_word(1'($urandom), 1'b0);
        if (rise_wait >= eff_rise) return;
        high_words = (echo_len > 32'(echo_limit_q)) ? 32'(echo_limit_q) + 1 : echo_len;
        repeat (high_words) push_word(1'($urandom), 1'b1);
        if (echo_len > 32'(echo_limit_q)) return;
        push_word(fall_start, 1'b0);
    endtask

    initial begin : run_test
        int unsigned mark;
        int unsigned eff_rise;
        int unsigned rise_wait;
        int unsigned echo_len;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: idle words with echo low and high, then one normal measurement
        push_word(1'b0, 1'b0);
        push_word(1'b0, 1'b1);
        add_measurement(1, 58, 1'b1);
        push_word(1'b0, 1'b1);
        settle();

        // Zero trigger lengths, zero rise timeout, zero echo limit
        program_ranger(0, 0, 0, 0, 1);
        add_measurement(1, 1, 1'b0);
        add_measurement(0, 1, 1'b0);
        settle();

        // Count up to the limit, one past it, rise timeout, start on the done tick
        program_ranger(1, 1, 3, 4, 255);
        add_measurement(2, 4, 1'b1);
        add_measurement(0, 5, 1'b0);
        add_measurement(3, 1, 1'b0);
        add_measurement(0, 1, 1'b1);
        settle();

        // Zero distance is not valid; smallest nonzero distance
        program_ranger(3, 2, 10, 58, 1);
        add_measurement(0, 57, 1'b0);
        add_measurement(5, 58, 1'b1);
        settle();

        // Full-scale timeout, limit and scale registers with a long echo, no idling
        no_idle = 1'b1;
        program_ranger(20, 1, 65535, 65535, 255);
        add_measurement(0, 200, 1'b0);
        settle();
        no_idle = 1'b0;

        // Random settings, mostly well-formed measurements plus noise
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            program_ranger($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(1, 40),
                           $urandom_range(1, 100), $urandom_range(1, 255));
            mark = words_queued;
            while (words_queued - mark < WORDS_PER_PHASE) begin
                if ($urandom_range(0, 9) < 8) begin
                    eff_rise  = (rise_tmo_q == '0) ? 1 : 32'(rise_tmo_q);
                    rise_wait = ($urandom_range(0, 6) == 0) ? eff_rise
                                                            : $urandom_range(0, eff_rise - 1);
                    echo_len  = ($urandom_range(0, 6) == 0)
                              ? 32'(echo_limit_q) + 1
                              : $urandom_range(1, 32'(echo_limit_q));
                    add_measurement(rise_wait, echo_len, 1'($urandom));
                    repeat ($urandom_range(0, 3)) push_word(1'b0, 1'($urandom));
                end else begin
                    repeat ($urandom_range(1, 6))
                        push_word($urandom_range(0, 3) == 0, 1'($urandom));
                end
            end
            if (p == 1) want_hold = 1'b1;
            settle();
        end

        repeat (16) @(posedge aclk);
        $display("Checked %0d tick words over %0d register settings plus reset values.",
                 results_seen, settings);
        $display("Measurements ended: %0d, timeouts: %0d, valid distances: %0d (max %0d).",
                 meas_done, tmo_seen, valid_seen, max_dist);
        if (mismatches == 0 && predicted_words.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d words still expected", mismatches,
                     predicted_words.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: ultrasonic_echo_ranger.f
rtl/uer_pkg.sv
rtl/uer_div58_step.sv
rtl/ultrasonic_echo_ranger.sv
dv/ultrasonic_echo_ranger_tb.sv
